// ===== hw/rtl/ialu_pkg.sv =====
// ialu_pkg: operation codes, item types and helpers for the 64-bit integer alu
// no dependencies
`default_nettype none
package ialu_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned OpW   = 4;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_REM = 4'd4,
    OP_EQ  = 4'd5,
    OP_NE  = 4'd6,
    OP_LT  = 4'd7,
    OP_LE  = 4'd8,
    OP_GT  = 4'd9,
    OP_GE  = 4'd10
  } op_e;

  // item class chosen by the front end
  typedef enum logic [1:0] {
    CL_FAST = 2'd0,
    CL_MUL  = 2'd1,
    CL_DIV  = 2'd2
  } class_e;

  typedef struct packed {
    class_e             cls;
    logic               is_rem;
    logic               neg_q;
    logic               neg_r;
    logic               err;
    logic [DataW-1:0]   a;
    logic [DataW-1:0]   b;
    logic [DataW-1:0]   fast;
  } item_t;

  function automatic logic [DataW-1:0] mag(input logic [DataW-1:0] x, input logic sgn);
    mag = (sgn && x[DataW-1]) ? (~x + 1'b1) : x;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/integer_alu_64bit.sv =====
// integer_alu_64bit: top level joining front end, item queue and back end
// depends on ialu_pkg, ialu_front, ialu_queue, ialu_back
`default_nettype none
// Every item passes through the front register and the item queue before it
// issues. Add, subtract and compare items issue back to back; a multiply then
// passes the partial-product register and the sum register of the pipelined
// 32x32 partial-product unit, a divide or remainder the one-bit-per-cycle
// divider and its finish flag, before the registered done_o. Fast and divide
// items behind a multiply, and all items behind a divide, wait so that results
// leave in issue order, one per done_o pulse; the receiver cannot stall them.
// busy rises while the item queue holds QueueDepth-1 or more items.
module integer_alu_64bit #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [ialu_pkg::OpW-1:0]    req_type_i,
  input  wire logic                        is_signed_i,
  input  wire logic [ialu_pkg::DataW-1:0]  operand_a_i,
  input  wire logic [ialu_pkg::DataW-1:0]  operand_b_i,
  output logic                             done_o,
  output logic [ialu_pkg::DataW-1:0]       result_value_o,
  output logic                             error_code_o
);

  ialu_pkg::item_t f_item, q_item;
  logic push, push_q, full, q_valid, pop;

  ialu_front u_front (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy),
    .req_type_i, .is_signed_i, .operand_a_i, .operand_b_i,
    .push_o(push), .item_o(f_item), .full_i(full)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) push_q <= 1'b0;
    else push_q <= push;
  end

  ialu_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push_q), .item_i(f_item), .full_o(full),
    .valid_o(q_valid), .item_o(q_item), .pop_i(pop)
  );

  ialu_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .item_i(q_item), .pop_o(pop),
    .done_o, .result_value_o, .error_code_o
  );

endmodule
`default_nettype wire

// ===== hw/rtl/ialu_front.sv =====
// ialu_front: accepts items, resolves add/sub/compare/error cases, prepares
// magnitudes for the divider; depends on ialu_pkg
`default_nettype none
module ialu_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [ialu_pkg::OpW-1:0]     req_type_i,
  input  wire logic                         is_signed_i,
  input  wire logic [ialu_pkg::DataW-1:0]   operand_a_i,
  input  wire logic [ialu_pkg::DataW-1:0]   operand_b_i,
  output logic                              push_o,
  output ialu_pkg::item_t                   item_o,
  input  wire logic                         full_i
);

  ialu_pkg::item_t it;
  logic lt_ab, lt_ba, eq;
  logic [ialu_pkg::DataW-1:0] xa, xb;

  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

  always_comb begin
    xa = operand_a_i ^ {is_signed_i, {(ialu_pkg::DataW-1){1'b0}}};
    xb = operand_b_i ^ {is_signed_i, {(ialu_pkg::DataW-1){1'b0}}};
    lt_ab = xa < xb;
    lt_ba = xb < xa;
    eq = operand_a_i == operand_b_i;
    it = '0;
    it.cls = ialu_pkg::CL_FAST;
    it.a = operand_a_i;
    it.b = operand_b_i;
    unique case (req_type_i)
      ialu_pkg::OP_ADD: it.fast = operand_a_i + operand_b_i;
      ialu_pkg::OP_SUB: it.fast = operand_a_i - operand_b_i;
      ialu_pkg::OP_MUL: it.cls = ialu_pkg::CL_MUL;
      ialu_pkg::OP_DIV, ialu_pkg::OP_REM: begin
        if (operand_b_i == '0) begin
          it.err = 1'b1;
        end else begin
          it.cls = ialu_pkg::CL_DIV;
          it.is_rem = req_type_i == ialu_pkg::OP_REM;
          it.neg_q = is_signed_i && (operand_a_i[ialu_pkg::DataW-1] ^
                                     operand_b_i[ialu_pkg::DataW-1]);
          it.neg_r = is_signed_i && operand_a_i[ialu_pkg::DataW-1];
          it.a = ialu_pkg::mag(operand_a_i, is_signed_i);
          it.b = ialu_pkg::mag(operand_b_i, is_signed_i);
        end
      end
      ialu_pkg::OP_EQ: it.fast = {63'd0, eq};
      ialu_pkg::OP_NE: it.fast = {63'd0, !eq};
      ialu_pkg::OP_LT: it.fast = {63'd0, lt_ab};
      ialu_pkg::OP_LE: it.fast = {63'd0, !lt_ba};
      ialu_pkg::OP_GT: it.fast = {63'd0, lt_ba};
      ialu_pkg::OP_GE: it.fast = {63'd0, !lt_ab};
      default: it.fast = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_o <= '0;
    end else if (push_o) begin
      item_o <= it;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ialu_queue.sv =====
// ialu_queue: small fifo of classified items between front and back end
// depends on ialu_pkg
`default_nettype none
module ialu_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire ialu_pkg::item_t   item_i,
  output logic                   full_o,
  output logic                   valid_o,
  output ialu_pkg::item_t        item_o,
  input  wire logic              pop_i
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  ialu_pkg::item_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rp_q];
  // leave room for the item registered in the front stage
  assign full_o  = cnt_q >= (AW+1)'(Depth - 1);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (pop_i) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ialu_back.sv =====
// ialu_back: executes queued items: pipelined multiplier and bit-serial
// divider; depends on ialu_pkg
`default_nettype none
module ialu_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire ialu_pkg::item_t             item_i,
  output logic                             pop_o,
  output logic                             done_o,
  output logic [ialu_pkg::DataW-1:0]       result_value_o,
  output logic                             error_code_o
);

  localparam int unsigned W = ialu_pkg::DataW;

  // multiplier: three 32x32 partial products, then sum
  logic        m1_v_q;
  logic [63:0] pll_q, plh_q, phl_q;
  logic        m2_v_q;
  logic [63:0] mres_q;

  // divider
  logic         dv_busy_q;
  logic [6:0]   dv_cnt_q;
  logic [W-1:0] dq_q, dr_q, db_q;
  logic         dv_rem_q, dv_nq_q, dv_nr_q;
  logic         dv_fin_q;
  logic [W:0]   trial;
  logic [W:0]   rsh;

  logic fast_go, mul_go, div_go;
  logic [W-1:0] dres;

  // a fast item may not collide with a multiply or divide finishing
  assign fast_go = valid_i && item_i.cls == ialu_pkg::CL_FAST && !m1_v_q && !m2_v_q
                   && !dv_fin_q && !dv_busy_q;
  assign mul_go  = valid_i && item_i.cls == ialu_pkg::CL_MUL && !dv_busy_q && !dv_fin_q;
  assign div_go  = valid_i && item_i.cls == ialu_pkg::CL_DIV && !dv_busy_q && !m1_v_q
                   && !m2_v_q && !dv_fin_q;
  assign pop_o   = fast_go || mul_go || div_go;

  assign rsh   = {dr_q, dq_q[W-1]};
  assign trial = rsh - {1'b0, db_q};
  assign dres  = dv_rem_q ? (dv_nr_q ? ~dr_q + 1'b1 : dr_q)
                          : (dv_nq_q ? ~dq_q + 1'b1 : dq_q);

  always_ff @(posedge clk_i) begin
    if (mul_go) begin
      pll_q <= item_i.a[31:0] * item_i.b[31:0];
      plh_q <= item_i.a[31:0] * item_i.b[63:32];
      phl_q <= item_i.a[63:32] * item_i.b[31:0];
    end
    mres_q <= pll_q + {plh_q[31:0] + phl_q[31:0], 32'd0};
    if (div_go) begin
      dq_q <= item_i.a;
      dr_q <= '0;
      db_q <= item_i.b;
      dv_rem_q <= item_i.is_rem;
      dv_nq_q <= item_i.neg_q;
      dv_nr_q <= item_i.neg_r;
    end else if (dv_busy_q) begin
      dq_q <= {dq_q[W-2:0], !trial[W]};
      dr_q <= trial[W] ? rsh[W-1:0] : trial[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      dv_busy_q <= 1'b0;
      dv_cnt_q <= '0;
      dv_fin_q <= 1'b0;
      done_o <= 1'b0;
      result_value_o <= '0;
      error_code_o <= 1'b0;
    end else begin
      m1_v_q <= mul_go;
      m2_v_q <= m1_v_q;
      dv_fin_q <= 1'b0;
      if (div_go) begin
        dv_busy_q <= 1'b1;
        dv_cnt_q <= 7'(W - 1);
      end else if (dv_busy_q) begin
        dv_cnt_q <= dv_cnt_q - 1'b1;
        if (dv_cnt_q == '0) begin
          dv_busy_q <= 1'b0;
          dv_fin_q <= 1'b1;
        end
      end
      done_o <= fast_go || m2_v_q || dv_fin_q;
      if (m2_v_q) begin
        result_value_o <= mres_q;
        error_code_o <= 1'b0;
      end else if (dv_fin_q) begin
        result_value_o <= dres;
        error_code_o <= 1'b0;
      end else begin
        result_value_o <= item_i.fast;
        error_code_o <= item_i.err;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0({fast_go, mul_go, div_go}))
    else $error("two issue paths at once");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(m2_v_q && dv_fin_q))
    else $error("multiply and divide finish together");
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_go |=> dv_busy_q)
    else $error("divider not started");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (dv_busy_q && dv_cnt_q == '0) |=> dv_fin_q)
    else $error("divider did not finish");

endmodule
`default_nettype wire
